### design/bls_pkg.sv
// Shared types, constants and command/status bundles for the line scaler.
package bls_pkg;

    localparam int PIX_W         = 16;
    localparam int WID_W         = 13;
    localparam int DIV_W         = WID_W + 1;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_OUT_DEF   = 64;

    // Register index codes, decoded from paddr[2].
    localparam logic REG_SRC_WIDTH = 1'b0;
    localparam logic REG_TGT_WIDTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_STEP,
        ST_DIV_SKIP,
        ST_MAIN,
        ST_TAIL
    } bls_state_t;

    typedef enum logic {
        DIV_SEL_STEP,
        DIV_SEL_SKIP
    } bls_div_sel_t;

    typedef struct packed {
        logic [WID_W-1:0] src_width;
        logic [WID_W-1:0] tgt_width;
        logic             restart;
    } bls_cfg_t;

    typedef struct packed {
        logic         take_px;
        logic         start_div;
        bls_div_sel_t div_sel;
        logic         load_step;
        logic         init_line;
        logic         main_step;
        logic         tail_step;
        logic         finish;
    } bls_cmd_t;

    typedef struct packed {
        logic line_start;
        logic div_done;
        logic upscale;
        logic main_hit;
        logic tail_hit;
        logic out_free;
        logic cap_hit;
    } bls_stat_t;

endpackage

### design/bresenham_line_scaler_unit.sv
// Top level of the Bresenham line scaler: register file, controller and datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------
//  input   | in        | in_valid/in_ready  | pixel_in
//  output  | out       | out_valid/out_ready| pixel_out, line_end
//  config  | in/out    | APB psel/penable   | paddr, pwdata, prdata
//
// A source pixel is taken in the idle state, then takes one main or tail step per target
// mapped to it, including targets dropped past the per-pixel cap, before it finishes;
// a stalled output holds the target loop. The first pixel of a line adds one division in
// the shared restoring divider, two when upscaling (step, then tail length).
// Reset returns both widths to 1 and starts a new line; any register write also
// restarts the line. The input is taken only when the controller is idle, while a
// finished result may still wait in the output register.
module bresenham_line_scaler_unit #(
    parameter int MAX_WIDTH         = bls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_OUT_PER_PIXEL = bls_pkg::MAX_OUT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bls_pkg::PIX_W-1:0]  pixel_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bls_pkg::PIX_W-1:0]  pixel_out,
    output logic                       line_end,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bls_pkg::ADDR_W-1:0] paddr,
    input  logic [bls_pkg::DATA_W-1:0] pwdata,
    output logic [bls_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bls_pkg::*;

    bls_cfg_t  cfg;
    bls_cmd_t  cmd;
    bls_stat_t stat;

    bls_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    bls_dp #(
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_OUT_PER_PIXEL (MAX_OUT_PER_PIXEL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .pixel_in  (pixel_in),
        .out_ready (out_ready),
        .stat      (stat),
        .out_valid (out_valid),
        .pixel_out (pixel_out),
        .line_end  (line_end)
    );

endmodule

### design/bls_cfg.sv
// APB register file holding the source and target line widths.
module bls_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bls_pkg::ADDR_W-1:0] paddr,
    input  logic [bls_pkg::DATA_W-1:0] pwdata,
    output logic [bls_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bls_pkg::bls_cfg_t          cfg
);
    import bls_pkg::*;

    logic [WID_W-1:0] src_width_reg;
    logic [WID_W-1:0] tgt_width_reg;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg <= WID_W'(1);
            tgt_width_reg <= WID_W'(1);
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SRC_WIDTH)
            begin
                src_width_reg <= pwdata[WID_W-1:0];
            end
            else
            begin
                tgt_width_reg <= pwdata[WID_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_SRC_WIDTH)
        begin
            prdata = DATA_W'(src_width_reg);
        end
        else
        begin
            prdata = DATA_W'(tgt_width_reg);
        end
    end

    assign cfg.src_width = src_width_reg;
    assign cfg.tgt_width = tgt_width_reg;
    assign cfg.restart   = wr_en;

endmodule

### design/bls_div.sv
// Restoring divider, one quotient bit per cycle.
module bls_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bls_pkg::DIV_W-1:0] num,
    input  logic [bls_pkg::DIV_W-1:0] den,
    output logic                      done,
    output logic [bls_pkg::DIV_W-1:0] quo,
    output logic [bls_pkg::DIV_W-1:0] rem
);
    import bls_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};
    assign done    = busy_reg && (cnt_reg == '0);
    assign quo     = quo_reg;
    assign rem     = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

endmodule

### design/bls_dp.sv
// Datapath: line state, Bresenham stepping, divider and output register.
module bls_dp #(
    parameter int MAX_WIDTH         = bls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_OUT_PER_PIXEL = bls_pkg::MAX_OUT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bls_pkg::bls_cfg_t         cfg,
    input  bls_pkg::bls_cmd_t         cmd,
    input  logic [bls_pkg::PIX_W-1:0] pixel_in,
    input  logic                      out_ready,
    output bls_pkg::bls_stat_t        stat,
    output logic                      out_valid,
    output logic [bls_pkg::PIX_W-1:0] pixel_out,
    output logic                      line_end
);
    import bls_pkg::*;

    localparam int               WID_MAX = (1 << WID_W) - 1;
    localparam logic [WID_W-1:0] MAX_W   =
        WID_W'((MAX_WIDTH > WID_MAX) ? WID_MAX : MAX_WIDTH);
    localparam int               N_W     = $clog2(MAX_OUT_PER_PIXEL + 1);
    localparam logic [N_W-1:0]   N_CAP   = N_W'(MAX_OUT_PER_PIXEL);

    logic [WID_W-1:0] in_index_reg;
    logic [WID_W-1:0] mapped_reg;
    logic [WID_W-1:0] err_reg;
    logic [WID_W-1:0] step_whole_reg;
    logic [WID_W-1:0] step_frac_reg;
    logic [WID_W-1:0] targets_left_reg;
    logic [WID_W-1:0] tail_reg;
    logic [PIX_W-1:0] px_reg;
    logic [N_W-1:0]   n_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             line_end_reg;

    logic [WID_W-1:0] src;
    logic [WID_W-1:0] tgt;
    logic [DIV_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;
    logic [WID_W-1:0] skip;
    logic [WID_W-1:0] tl_init;
    logic [WID_W-1:0] mapped_sum;
    logic [WID_W-1:0] err_sum;
    logic [WID_W-1:0] mapped_next;
    logic [WID_W-1:0] err_next;
    logic [WID_W-1:0] src_last;
    logic [WID_W-1:0] sat;
    logic [WID_W-1:0] in_index_inc;
    logic             cap_hit;
    logic             write_out;
    logic             end_flag;

    function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
        logic [WID_W-1:0] r;
        if (w == '0)
        begin
            r = WID_W'(1);
        end
        else if (w > MAX_W)
        begin
            r = MAX_W;
        end
        else
        begin
            r = w;
        end
        return r;
    endfunction

    assign src = eff_width(cfg.src_width);
    assign tgt = eff_width(cfg.tgt_width);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SEL_STEP:
            begin
                div_num = {1'b0, src};
                div_den = {1'b0, tgt};
            end
            DIV_SEL_SKIP:
            begin
                div_num = {1'b0, tgt};
                div_den = {src, 1'b0};
            end
            default:
            begin
                div_num = {1'b0, src};
                div_den = {1'b0, tgt};
            end
        endcase
    end

    bls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // The skip quotient is only live in the second division, which runs for upscaling only.
    assign skip    = (tgt >= src) ? (div_quo[WID_W-1:0] + WID_W'(1)) : '0;
    assign tl_init = (skip <= tgt) ? (tgt - skip) : '0;

    assign mapped_sum = mapped_reg + step_whole_reg;
    assign err_sum    = err_reg + step_frac_reg;
    always_comb
    begin
        if (err_sum >= tgt)
        begin
            err_next    = err_sum - tgt;
            mapped_next = mapped_sum + WID_W'(1);
        end
        else
        begin
            err_next    = err_sum;
            mapped_next = mapped_sum;
        end
    end

    assign src_last     = src - WID_W'(1);
    assign sat          = (mapped_reg > src_last) ? src_last : mapped_reg;
    assign in_index_inc = in_index_reg + WID_W'(1);

    assign cap_hit   = (n_reg == N_CAP);
    assign write_out = (cmd.main_step || cmd.tail_step) && !cap_hit;
    assign end_flag  = cmd.tail_step ? (tail_reg == WID_W'(1))
                                     : ((targets_left_reg == WID_W'(1)) && (tail_reg == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_index_reg     <= '0;
            mapped_reg       <= '0;
            err_reg          <= '0;
            step_whole_reg   <= '0;
            step_frac_reg    <= '0;
            targets_left_reg <= '0;
            tail_reg         <= '0;
            n_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.restart)
            begin
                in_index_reg <= '0;
            end
            else if (cmd.finish)
            begin
                in_index_reg <= (in_index_inc >= src) ? '0 : in_index_inc;
            end

            if (cmd.load_step)
            begin
                step_whole_reg <= div_quo[WID_W-1:0];
                step_frac_reg  <= div_rem[WID_W-1:0];
            end

            if (cmd.init_line)
            begin
                targets_left_reg <= tl_init;
                tail_reg         <= skip;
                mapped_reg       <= '0;
                err_reg          <= '0;
            end
            else if (cmd.main_step)
            begin
                targets_left_reg <= targets_left_reg - WID_W'(1);
                mapped_reg       <= mapped_next;
                err_reg          <= err_next;
            end
            else if (cmd.tail_step)
            begin
                tail_reg <= tail_reg - WID_W'(1);
            end

            if (cmd.take_px)
            begin
                n_reg <= '0;
            end
            else if (write_out)
            begin
                n_reg <= n_reg + N_W'(1);
            end

            if (write_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_px)
        begin
            px_reg <= pixel_in;
        end
        if (write_out)
        begin
            pixel_out_reg <= px_reg;
            line_end_reg  <= end_flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign line_end  = line_end_reg;

    assign stat.line_start = (in_index_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.upscale    = (tgt >= src);
    assign stat.main_hit   = (targets_left_reg != '0) && (mapped_reg == in_index_reg);
    assign stat.tail_hit   = (targets_left_reg == '0) && (sat == in_index_reg)
                             && (tail_reg != '0);
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.cap_hit    = cap_hit;

endmodule

### design/bls_ctrl.sv
// Controller state machine sequencing line setup and target emission.
module bls_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bls_pkg::bls_stat_t stat,
    output logic               in_ready,
    output bls_pkg::bls_cmd_t  cmd
);
    import bls_pkg::*;

    bls_state_t state_reg;
    bls_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SEL_STEP;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_px = 1'b1;
                    if (stat.line_start)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = ST_DIV_STEP;
                    end
                    else
                    begin
                        state_next = ST_MAIN;
                    end
                end
            end
            ST_DIV_STEP:
            begin
                if (stat.div_done)
                begin
                    cmd.load_step = 1'b1;
                    if (stat.upscale)
                    begin
                        cmd.start_div = 1'b1;
                        cmd.div_sel   = DIV_SEL_SKIP;
                        state_next    = ST_DIV_SKIP;
                    end
                    else
                    begin
                        cmd.init_line = 1'b1;
                        state_next    = ST_MAIN;
                    end
                end
            end
            ST_DIV_SKIP:
            begin
                cmd.div_sel = DIV_SEL_SKIP;
                if (stat.div_done)
                begin
                    cmd.init_line = 1'b1;
                    state_next    = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                // Requests past the per-pixel cap are stepped without waiting on the output.
                if (stat.main_hit)
                begin
                    cmd.main_step = stat.out_free || stat.cap_hit;
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (stat.tail_hit)
                begin
                    cmd.tail_step = stat.out_free || stat.cap_hit;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/bls_chk.sv
// Port-level checker for the line scaler and its bind to the top level.
module bls_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [bls_pkg::PIX_W-1:0]  pixel_in,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [bls_pkg::PIX_W-1:0]  pixel_out,
    input logic                       line_end,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [bls_pkg::ADDR_W-1:0] paddr,
    input logic [bls_pkg::DATA_W-1:0] pwdata,
    input logic [bls_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);
    import bls_pkg::*;

    logic src_wr;
    logic src_rd;
    logic any_wr;

    assign any_wr = psel && penable && pwrite && pready;
    assign src_wr = any_wr && (paddr[2] == REG_SRC_WIDTH);
    assign src_rd = psel && penable && !pwrite && (paddr[2] == REG_SRC_WIDTH);

    // A waiting input request keeps its pixel until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(pixel_in))
        else $error("input request changed while waiting");

    // A held result must not change while the consumer stalls it.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(line_end))
        else $error("output request changed while stalled");

    // One source pixel at a time: the input closes right after a request is taken.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened directly after a request");

    // Results start only while a pixel is being worked on.
    a_out_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result started while the scaler was idle");

    // The source width reads back what was last written to it.
    a_src_readback: assert property (@(posedge clk) disable iff (!rst_n)
        src_wr ##1 !any_wr ##1 src_rd |->
            prdata == DATA_W'($past(pwdata[WID_W-1:0], 2)))
        else $error("source width read back wrong");

endmodule

bind bresenham_line_scaler_unit bls_chk u_bls_chk (.*);

### tb/tb.sv
// Testbench for the Bresenham line scaler: predicts target pixels and checks them in order.
`timescale 1ns / 100ps

module tb;
    import bls_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_PIXELS  = 255;
    localparam int LONG_HOLD      = 600;

    // Predicts the target pixels of the line and holds those not yet seen.
    class target_scoreboard;
        typedef struct packed {
            logic [PIX_W-1:0] pix;
            logic             last;
        } target_t;

        logic [WID_W-1:0] src_reg;
        logic [WID_W-1:0] tgt_reg;
        logic [WID_W-1:0] pos;
        logic [WID_W-1:0] next_map;
        logic [WID_W-1:0] err;
        logic [WID_W-1:0] step_int;
        logic [WID_W-1:0] step_rem;
        logic [WID_W-1:0] main_left;
        logic [WID_W-1:0] tail_left;
        target_t          due_targets[$];
        int               errors;

        function new();
            src_reg   = 1;
            tgt_reg   = 1;
            pos       = '0;
            next_map  = '0;
            err       = '0;
            step_int  = '0;
            step_rem  = '0;
            main_left = '0;
            tail_left = '0;
            errors    = 0;
        endfunction

        static function int unsigned active_width(logic [WID_W-1:0] w);
            if (w == 0)
                return 1;
            if (w > MAX_WIDTH_DEF)
                return MAX_WIDTH_DEF;
            return w;
        endfunction

        function int unsigned busy_bound();
            return active_width(tgt_reg) + 48;
        endfunction

        function void write_reg(logic sel, logic [DATA_W-1:0] value);
            if (sel == REG_SRC_WIDTH)
                src_reg = value[WID_W-1:0];
            else
                tgt_reg = value[WID_W-1:0];
            pos = '0;
        endfunction

        function void map_source_pixel(logic [PIX_W-1:0] px);
            int unsigned src;
            int unsigned tgt;
            int unsigned skip;
            int unsigned sat;
            int          n;
            target_t     t;
            src = active_width(src_reg);
            tgt = active_width(tgt_reg);
            n   = 0;
            if (pos == 0)
            begin
                skip      = (tgt < src) ? 0 : tgt / (2 * src) + 1;
                step_int  = WID_W'(src / tgt);
                step_rem  = WID_W'(src % tgt);
                main_left = (skip <= tgt) ? WID_W'(tgt - skip) : '0;
                tail_left = WID_W'(skip);
                next_map  = '0;
                err       = '0;
            end
            while (main_left != 0 && next_map == pos)
            begin
                main_left--;
                // Targets past the per-pixel cap are consumed but never leave the block.
                if (n < MAX_OUT_DEF)
                begin
                    t.pix  = px;
                    t.last = (main_left == 0 && tail_left == 0);
                    due_targets.push_back(t);
                    n++;
                end
                next_map = next_map + step_int;
                err      = err + step_rem;
                if (err >= tgt)
                begin
                    err      = err - WID_W'(tgt);
                    next_map = next_map + 1'b1;
                end
            end
            sat = (next_map > src - 1) ? src - 1 : next_map;
            if (main_left == 0 && sat == pos)
            begin
                while (tail_left != 0)
                begin
                    tail_left--;
                    if (n < MAX_OUT_DEF)
                    begin
                        t.pix  = px;
                        t.last = (tail_left == 0);
                        due_targets.push_back(t);
                        n++;
                    end
                end
            end
            pos = pos + 1'b1;
            if (pos >= src)
                pos = '0;
        endfunction

        function void check_target(logic [PIX_W-1:0] px, logic last);
            target_t t;
            if (due_targets.size() == 0)
            begin
                $error("unexpected target pixel: pixel_out %h, line_end %b", px, last);
                errors++;
                return;
            end
            t = due_targets.pop_front();
            if (t.pix !== px)
            begin
                $error("pixel_out mismatch: expected %h, actual %h", t.pix, px);
                errors++;
            end
            if (t.last !== last)
            begin
                $error("line_end mismatch: expected %b, actual %b", t.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  pixel_in  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [PIX_W-1:0]  pixel_out;
    logic              line_end;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    target_scoreboard sb = new();

    int pixels_sent = 0;
    int idle_cycles = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int rx_pct      = 100;
    int rx_left     = 0;

    bresenham_line_scaler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .line_end  (line_end),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // The receiver changes its stall rate now and then; a requested hold-off overrides it.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: rx_pct = 100;
                    1: rx_pct = 50;
                    2: rx_pct = 25;
                    default: rx_pct = 85;
                endcase
                rx_left = $urandom_range(8, 80);
            end
            rx_left--;
            out_ready <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_target(pixel_out, line_end);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bresenham_line_scaler_unit verification failed");
                $finish;
            end
        end
    end

    function automatic logic [WID_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return WID_W'($urandom_range(1, 12));
        if (r < 85)
            return WID_W'($urandom_range(13, 200));
        if (r < 92)
        begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return WID_W'(MAX_WIDTH_DEF);
                default: return '1;
            endcase
        end
        return WID_W'($urandom_range(MAX_WIDTH_DEF + 1, 8191));
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Leaves in_valid high so that a following request can go out back to back.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        in_valid <= 1'b1;
        pixel_in <= px;
        do
            @(posedge clk);
        while (!in_ready);
        sb.map_source_pixel(px);
        pixels_sent++;
    endtask

    task automatic stream_pixels(input int count, input int pause_at);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.due_targets.size() != 0);
            end
            else if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            send_pixel(pick_pixel());
            if (burst_left > 0)
                burst_left--;
        end
        in_valid <= 1'b0;
    endtask

    task automatic apb_write(input logic sel, input logic [WID_W-1:0] width);
        logic [DATA_W-1:0] word;
        word = {(DATA_W - WID_W)'($urandom), width};
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(sel, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only once the block has drained and finished any dropped targets.
    task automatic set_widths(input logic [WID_W-1:0] src, input logic [WID_W-1:0] tgt);
        while (sb.due_targets.size() != 0)
            @(posedge clk);
        repeat (sb.busy_bound()) @(posedge clk);
        apb_write(REG_SRC_WIDTH, src);
        apb_write(REG_TGT_WIDTH, tgt);
    endtask

    initial
    begin
        logic [WID_W-1:0] src;
        logic [WID_W-1:0] tgt;
        int               count;
        int               phase_no;
        int unsigned      s;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset widths of one: each pixel is a whole line.
        send_pixel('0);
        send_pixel('1);
        in_valid <= 1'b0;

        // Zero and oversized widths clamp; one pixel maps to far more targets than the cap.
        set_widths('0, '1);
        stream_pixels(1, -1);

        // Downscaling leaves trailing pixels of the line with nothing to emit.
        set_widths(8, 3);
        stream_pixels(10, -1);

        // A register write in the middle of a line starts a new one.
        set_widths(5, 13);
        stream_pixels(3, -1);
        set_widths(5, 13);
        stream_pixels(5, -1);

        set_widths(WID_W'(MAX_WIDTH_DEF), 1);
        stream_pixels(2, -1);
        set_widths(5000, WID_W'(MAX_WIDTH_DEF));
        stream_pixels(2, -1);

        phase_no = 0;
        count    = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < count)
        begin
            if (phase_no == 0)
            begin
                src = 3;
                tgt = 40;
            end
            else
            begin
                src = pick_width();
                tgt = pick_width();
            end
            set_widths(src, tgt);
            s = target_scoreboard::active_width(src);
            if (phase_no == 0)
            begin
                // The output is held off while requests keep coming, so the block backs up.
                hold_asked++;
                stream_pixels(12, -1);
            end
            else if (target_scoreboard::active_width(tgt) > 512)
                stream_pixels($urandom_range(1, 4), -1);
            else if (s <= 10)
                stream_pixels($urandom_range(1, 3 * s + 3), (phase_no == 1) ? 2 : -1);
            else
                stream_pixels($urandom_range(4, 30), (phase_no == 1) ? 2 : -1);
            phase_no++;
        end

        while (sb.due_targets.size() != 0)
            @(posedge clk);
        repeat (sb.busy_bound()) @(posedge clk);

        if (sb.errors == 0 && sb.due_targets.size() == 0)
            $display("bresenham_line_scaler_unit verification clean");
        else
            $display("bresenham_line_scaler_unit verification failed");
        $finish;
    end

endmodule

### bresenham_line_scaler_unit.f
design/bls_pkg.sv
design/bls_cfg.sv
design/bls_div.sv
design/bls_dp.sv
design/bls_ctrl.sv
design/bresenham_line_scaler_unit.sv
design/bls_chk.sv
tb/tb.sv
